@@ hdl/lph_pkg.sv @@
// ----------------------------------------------------------------------------
// lph_pkg
// Shared request and response codes for the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

	// request operation codes
	typedef enum logic [2:0] {
		KIND_INSERT = 3'd0,
		KIND_UPSERT = 3'd1,
		KIND_FIND   = 3'd2,
		KIND_REMOVE = 3'd3,
		KIND_CLEAR  = 3'd4
	} kind_t;

	// response status codes
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_DUPLICATE = 3'd4,
		ST_FULL      = 3'd5,
		ST_REMOVED   = 3'd6
	} status_t;

	localparam int unsigned BUCKET_W = 10;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned FIELD_W  = 32;

endpackage

@@ hdl/lph_ram.sv @@
// ----------------------------------------------------------------------------
// lph_ram
// Single write, single read synchronous memory with a registered read port
// and a write-to-read bypass for the same address in the same cycle.
// ----------------------------------------------------------------------------
module lph_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 75
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [WIDTH-1:0] fwd_q;
	logic             byp_q;

	// array write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// bypass when the word being read is written in the same cycle
	always_ff @(posedge clk) begin
		byp_q <= we && (waddr == raddr);
		fwd_q <= wdata;
	end

	assign rdata = byp_q ? fwd_q : rd_q;

endmodule

@@ hdl/linear_probe_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing and backward-shift removal.
// ----------------------------------------------------------------------------
// Usage:
// A request word (kind, key, value, key_hash) is taken on req_valid when
// req_stall is low; one response word (status, bucket, found_value,
// live_count) is offered on rsp_valid and held until rsp_stall is low.
// Requests are handled one at a time; the next is taken as soon as the
// previous response sits in the output register, even if it is stalled.
// The entry memory has one write and one read port; a probe examines one
// bucket per cycle. Find, insert and update probe P buckets (1..BUCKETS);
// remove probes P buckets and then walks S buckets in the shift repair;
// clear all sweeps over every bucket.
// After reset a sweep over every bucket empties the table; req_stall is
// high until it completes. A stalled response holds the block in its
// final step and the next request waits.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
	parameter int unsigned BUCKETS    = 1024,
	parameter int unsigned KEY_BITS   = 32,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic [31:0] key_hash,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [9:0]  bucket,
	output logic [31:0] found_value,
	output logic [10:0] live_count
);

	localparam int unsigned IW = $clog2(BUCKETS);
	localparam int unsigned CW = $clog2(BUCKETS + 1);
	localparam logic [IW-1:0] LAST = IW'(BUCKETS - 1);

	typedef struct packed {
		logic                  occ;
		logic [IW-1:0]         home;
		logic [KEY_BITS-1:0]   k;
		logic [VALUE_BITS-1:0] v;
	} entry_t;

	typedef enum logic [5:0] {
		S_SWEEP = 6'b000001,
		S_IDLE  = 6'b000010,
		S_PROBE = 6'b000100,
		S_SHIFT = 6'b001000,
		S_SHFIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                state_q, state_d;
	logic [IW-1:0]         idx_q, idx_d;
	logic [IW-1:0]         n_q, n_d;
	logic [IW-1:0]         hole_q, hole_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic                  report_q, report_d;
	lph_pkg::kind_t        kind_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IW-1:0]         home_q;
	lph_pkg::status_t      res_st_q, res_st_d;
	logic [IW-1:0]         res_bkt_q, res_bkt_d;
	logic [VALUE_BITS-1:0] res_val_q, res_val_d;

	logic                  rsp_valid_q;
	logic [2:0]            status_q;
	logic [9:0]            bucket_q;
	logic [31:0]           found_value_q;
	logic [10:0]           live_count_q;

	logic                  we;
	logic [IW-1:0]         waddr;
	entry_t                wdata;
	logic [IW-1:0]         raddr;
	entry_t                rd;
	logic [$bits(entry_t)-1:0] rd_bits;

	logic                  accept;
	logic [IW-1:0]         home_in;
	logic [IW-1:0]         idx_nx;
	logic                  occ_eff;
	logic                  hit;
	logic                  load_rsp;

	function automatic logic [IW-1:0] ring_dist(input logic [IW-1:0] from,
		input logic [IW-1:0] to);
		logic [IW:0] d;
		d = {1'b0, to} - {1'b0, from};
		if (d[IW]) begin
			d = d + (IW+1)'(BUCKETS);
		end
		return d[IW-1:0];
	endfunction

	// entry memory
	lph_ram #(
		.DEPTH (BUCKETS),
		.WIDTH ($bits(entry_t))
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_bits)
	);
	assign rd = entry_t'(rd_bits);

	// request decode
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign home_in   = key_hash[IW-1:0] & LAST;
	assign idx_nx    = (idx_q == LAST) ? '0 : idx_q + 1'b1;
	assign occ_eff   = rd.occ && !((state_q == S_SHIFT) && (idx_q == hole_q));
	assign hit       = rd.occ && (rd.k == key_q);
	assign load_rsp  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// sequencer
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		n_d       = n_q;
		hole_d    = hole_q;
		cnt_d     = cnt_q;
		report_d  = report_q;
		res_st_d  = res_st_q;
		res_bkt_d = res_bkt_q;
		res_val_d = res_val_q;
		raddr     = idx_q;
		we        = 1'b0;
		waddr     = idx_q;
		wdata     = '{occ: 1'b1, home: home_q, k: key_q, v: val_q};
		unique case (state_q)
			S_SWEEP: begin
				we    = 1'b1;
				wdata = '0;
				if (idx_q == LAST) begin
					state_d = report_q ? S_DONE : S_IDLE;
				end else begin
					idx_d = idx_nx;
				end
			end
			S_IDLE: begin
				if (accept) begin
					res_st_d  = lph_pkg::ST_NOT_FOUND;
					res_bkt_d = '0;
					res_val_d = '0;
					idx_d     = home_in;
					n_d       = '0;
					raddr     = home_in;
					unique case (kind)
						lph_pkg::KIND_INSERT, lph_pkg::KIND_UPSERT,
						lph_pkg::KIND_FIND, lph_pkg::KIND_REMOVE: begin
							state_d = S_PROBE;
						end
						lph_pkg::KIND_CLEAR: begin
							state_d  = S_SWEEP;
							idx_d    = '0;
							cnt_d    = '0;
							report_d = 1'b1;
							res_st_d = lph_pkg::ST_REMOVED;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_PROBE: begin
				if (!rd.occ) begin
					// empty bucket ends the probe
					state_d = S_DONE;
					if (kind_q == lph_pkg::KIND_INSERT || kind_q == lph_pkg::KIND_UPSERT) begin
						we        = 1'b1;
						cnt_d     = cnt_q + 1'b1;
						res_st_d  = lph_pkg::ST_INSERTED;
						res_bkt_d = idx_q;
					end
				end else if (hit) begin
					state_d = S_DONE;
					unique case (kind_q)
						lph_pkg::KIND_INSERT: begin
							res_st_d = lph_pkg::ST_DUPLICATE;
						end
						lph_pkg::KIND_UPSERT: begin
							we        = 1'b1;
							res_st_d  = lph_pkg::ST_UPDATED;
							res_bkt_d = idx_q;
						end
						lph_pkg::KIND_FIND: begin
							res_st_d  = lph_pkg::ST_FOUND;
							res_bkt_d = idx_q;
							res_val_d = rd.v;
						end
						default: begin
							// remove: start the backward-shift walk
							res_st_d  = lph_pkg::ST_REMOVED;
							res_bkt_d = idx_q;
							cnt_d     = cnt_q - 1'b1;
							hole_d    = idx_q;
							idx_d     = idx_nx;
							n_d       = '0;
							raddr     = idx_nx;
							state_d   = S_SHIFT;
						end
					endcase
				end else if (n_q == LAST) begin
					// full lap without a free bucket or a match
					state_d = S_DONE;
					if (kind_q == lph_pkg::KIND_INSERT || kind_q == lph_pkg::KIND_UPSERT) begin
						res_st_d = lph_pkg::ST_FULL;
					end
				end else begin
					idx_d = idx_nx;
					n_d   = n_q + 1'b1;
					raddr = idx_nx;
				end
			end
			S_SHIFT: begin
				if (!occ_eff) begin
					state_d = S_SHFIN;
				end else begin
					// move the entry back if the hole lies on its probe path
					if (ring_dist(hole_q, idx_q) <= ring_dist(rd.home, idx_q)) begin
						we     = 1'b1;
						waddr  = hole_q;
						wdata  = rd;
						hole_d = idx_q;
					end
					if (n_q == LAST) begin
						state_d = S_SHFIN;
					end else begin
						idx_d = idx_nx;
						n_d   = n_q + 1'b1;
						raddr = idx_nx;
					end
				end
			end
			S_SHFIN: begin
				we      = 1'b1;
				waddr   = hole_q;
				wdata   = '0;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_rsp) begin
					state_d  = S_IDLE;
					report_d = 1'b0;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_SWEEP;
			idx_q    <= '0;
			n_q      <= '0;
			hole_q   <= '0;
			cnt_q    <= '0;
			report_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			n_q      <= n_d;
			hole_q   <= hole_d;
			cnt_q    <= cnt_d;
			report_q <= report_d;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= lph_pkg::kind_t'(kind);
			key_q  <= KEY_BITS'(key);
			val_q  <= VALUE_BITS'(value);
			home_q <= home_in;
		end
		res_st_q  <= res_st_d;
		res_bkt_q <= res_bkt_d;
		res_val_q <= res_val_d;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			status_q      <= res_st_q;
			bucket_q      <= lph_pkg::BUCKET_W'(res_bkt_q);
			found_value_q <= lph_pkg::FIELD_W'(res_val_q);
			live_count_q  <= lph_pkg::COUNT_W'(cnt_q);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign bucket      = bucket_q;
	assign found_value = found_value_q;
	assign live_count  = live_count_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(BUCKETS))
		else $error("live count beyond table size");

	a_shfin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHFIN |=> state_q == S_DONE)
		else $error("shift repair did not finish");
`endif

endmodule
